// ----- sv/horizontal_to_vertical_page_bytes_unit_defines.svh -----
// Assertion macros shared by the horizontal-to-vertical page byte unit.
`ifndef HORIZONTAL_TO_VERTICAL_PAGE_BYTES_UNIT_DEFINES_SVH
`define HORIZONTAL_TO_VERTICAL_PAGE_BYTES_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Checks that the consequent holds in the same cycle as the antecedent.
`define H2V_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h2v assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define H2V_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h2v assertion failed");

`else

`define H2V_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define H2V_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/h2v_pkg.sv -----
// Types, constants and the cell transpose function of the page byte unit.
`default_nettype none

package h2v_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_VALUE_W  = 11;
    localparam int WIDTH_REG_W  = 9;
    localparam int HEIGHT_REG_W = 11;

    // Rows 0 to 6 of a page are stored; row 7 is never written to the store.
    localparam int STORE_LANES = 7;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET     = 9'd128;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET    = 11'd64;
    localparam logic                    BIT_ORDER_RESET = 1'b0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BIT_ORDER    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] source_byte;
    } src_item_t;

    typedef struct packed {
        logic [7:0] column_byte;
        logic [7:0] column_index;
        logic [6:0] page_index;
        logic       last_of_cell;
    } dst_item_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_VALUE_W-1:0] value;
    } cfg_item_t;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [2:0] lane;
    } store_ctl_t;

    // Eight vertical bytes, entry c is pixel column c of the cell.
    typedef logic [7:0][7:0] col_set_t;

    // Cell byte r holds page row r with its leftmost pixel in bit 7.
    function automatic col_set_t h2v_transpose(input logic [63:0] tile,
                                               input logic top_in_msb);
        col_set_t cols;
        cols = '0;
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 8; r++) begin
                if (top_in_msb) begin
                    cols[c][7-r] = tile[8*r + 7 - c];
                end
                else begin
                    cols[c][r] = tile[8*r + 7 - c];
                end
            end
        end
        return cols;
    endfunction

endpackage

`default_nettype wire

// ----- sv/h2v_if.sv -----
// Valid/ready channel interfaces for the input, result and register ports.
`default_nettype none

interface h2v_src_if;
    import h2v_pkg::*;
    logic      valid;
    logic      ready;
    src_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface h2v_dst_if;
    import h2v_pkg::*;
    logic      valid;
    logic      ready;
    dst_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface h2v_cfg_if;
    import h2v_pkg::*;
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/h2v_page_store.sv -----
// Line store holding rows 0 to 6 of the current page, one entry per byte column.
`default_nettype none

module h2v_page_store #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                                 clk,
    input  h2v_pkg::store_ctl_t                  ctl,
    input  logic [ADDR_W-1:0]                    addr,
    input  logic [7:0]                           wr_byte,
    output logic [h2v_pkg::STORE_LANES*8-1:0]    rd_data
);
    import h2v_pkg::*;

    logic [STORE_LANES-1:0][7:0] mem [DEPTH];
    logic [STORE_LANES-1:0][7:0] rd_data_reg;

    // Each row lands in its own byte lane, so a write leaves the other rows alone.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr][ctl.lane] <= wr_byte;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/horizontal_to_vertical_page_bytes_unit.sv -----
// Top level of the horizontal-to-vertical page byte converter.
//
//  Port  | Role    | Payload                                         | Per transaction
//  ------+---------+-------------------------------------------------+------------------------
//  src   | sink    | source_byte                                     | one row-major byte
//  dst   | source  | column_byte, column_index, page_index,          | one vertical byte
//        |         | last_of_cell                                    |
//  cfg   | sink    | index, value                                    | one register write
//
// Bytes of page rows 0 to 6 go into the line store; the byte that closes a cell (page
// row 7, or the image's last row) reads it, and the cell's up to eight column bytes
// leave at one per cycle while dst.ready is high. A closing byte parks in a one-entry
// holding stage until the emitter is empty or its last column is accepted; src.ready
// is low only while that stage holds a byte that cannot move on. The store needs no
// clearing; rst_n clears counters, registers and valid flags asynchronously.
`default_nettype none
`include "horizontal_to_vertical_page_bytes_unit_defines.svh"

module horizontal_to_vertical_page_bytes_unit #(
    parameter int MAX_WIDTH  = h2v_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = h2v_pkg::MAX_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    h2v_src_if.sink   src,
    h2v_dst_if.source dst,
    h2v_cfg_if.sink   cfg
);
    import h2v_pkg::*;

    // One store entry per byte column of the widest image.
    localparam int STORE_DEPTH = (MAX_WIDTH + 7) / 8;
    localparam int BC_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    // Comparison widths hold the register value, the limit and one more bit.
    localparam int WC_W = ((WIDTH_REG_W > $clog2(MAX_WIDTH + 1)) ?
                           WIDTH_REG_W : $clog2(MAX_WIDTH + 1)) + 1;
    localparam int HC_W = ((HEIGHT_REG_W > $clog2(MAX_HEIGHT + 1)) ?
                           HEIGHT_REG_W : $clog2(MAX_HEIGHT + 1)) + 1;

    // ---------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index past the
    // register list is accepted and ignored.
    // ---------------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    bit_order_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            bit_order_reg <= BIT_ORDER_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_IMAGE_WIDTH:  width_reg     <= cfg.data.value[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= cfg.data.value[HEIGHT_REG_W-1:0];
                REG_BIT_ORDER:    bit_order_reg <= cfg.data.value[0];
                default:          ;
            endcase
        end
    end

    // Effective image size: zero counts as one, anything above the limit as the limit.
    logic [WC_W-1:0] w_raw;
    logic [WC_W-1:0] w_eff;
    logic [HC_W-1:0] h_raw;
    logic [HC_W-1:0] h_eff;
    logic [WC_W-1:0] bytes_per_row;

    assign w_raw = WC_W'(width_reg);
    assign h_raw = HC_W'(height_reg);

    always_comb
    begin
        if (w_raw == '0)
        begin
            w_eff = WC_W'(1);
        end
        else if (w_raw > WC_W'(MAX_WIDTH))
        begin
            w_eff = WC_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end

        if (h_raw == '0)
        begin
            h_eff = HC_W'(1);
        end
        else if (h_raw > HC_W'(MAX_HEIGHT))
        begin
            h_eff = HC_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_raw;
        end
    end

    assign bytes_per_row = (w_eff + WC_W'(7)) >> 3;

    // ---------------------------------------------------------------------------
    // Position counters and classification of the incoming byte.
    // ---------------------------------------------------------------------------
    logic [BC_W-1:0]  byte_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    logic             src_fire;
    logic [2:0]       page_row;
    logic             last_row;
    logic             last_byte;
    logic             closes_cell;
    logic [WC_W-1:0]  byte_first_px;
    logic [WC_W-1:0]  px_left;
    logic             has_cols;
    logic [2:0]       last_col;
    logic [ROW_W+6:0] row_wide;
    logic [6:0]       page_now;

    assign src_fire      = src.valid && src.ready;
    assign page_row      = row_cnt_reg[2:0];
    assign last_row      = (HC_W'(row_cnt_reg) + HC_W'(1)) >= h_eff;
    assign last_byte     = (WC_W'(byte_cnt_reg) + WC_W'(1)) >= bytes_per_row;
    assign closes_cell   = (page_row == 3'd7) || last_row;
    assign byte_first_px = WC_W'({byte_cnt_reg, 3'b000});
    assign has_cols      = byte_first_px < w_eff;
    assign px_left       = w_eff - byte_first_px;
    // A byte column that reaches past the width sends only its columns inside the image.
    assign last_col      = (px_left > WC_W'(8)) ? 3'd7 : 3'(px_left - WC_W'(1));
    assign row_wide      = (ROW_W + 7)'(row_cnt_reg);
    assign page_now      = row_wide[9:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            row_cnt_reg  <= '0;
        end
        else if (src_fire)
        begin
            if (last_byte)
            begin
                byte_cnt_reg <= '0;
                row_cnt_reg  <= last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                byte_cnt_reg <= byte_cnt_reg + BC_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Line store. Rows 0 to 6 are written; a closing byte reads its byte column.
    // A closing byte whose columns all lie past the width produces nothing.
    // ---------------------------------------------------------------------------
    store_ctl_t                   store_ctl;
    logic [STORE_LANES*8-1:0]     store_rd_data;

    assign store_ctl.wr_en = src_fire && !closes_cell;
    assign store_ctl.rd_en = src_fire && closes_cell && has_cols;
    assign store_ctl.lane  = page_row;

    h2v_page_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (BC_W)
    ) u_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .addr    (byte_cnt_reg),
        .wr_byte (src.data.source_byte),
        .rd_data (store_rd_data)
    );

    // ---------------------------------------------------------------------------
    // Holding stage: the closing byte and its position wait here while the store
    // read completes and, if needed, until the emitter is free.
    // ---------------------------------------------------------------------------
    logic            hold_valid_reg;
    logic [7:0]      hold_byte_reg;
    logic [2:0]      hold_prow_reg;
    logic [BC_W-1:0] hold_bcol_reg;
    logic [2:0]      hold_lcol_reg;
    logic [6:0]      hold_page_reg;

    logic            emit_valid_reg;
    logic [2:0]      emit_col_reg;
    logic [2:0]      emit_lcol_reg;
    logic [BC_W-1:0] emit_bcol_reg;
    logic [6:0]      emit_page_reg;
    col_set_t        emit_cols_reg;

    logic            dst_fire;
    logic            emit_on_last;
    logic            emit_free;
    logic            hold_move;

    assign dst_fire     = dst.valid && dst.ready;
    assign emit_on_last = emit_col_reg == emit_lcol_reg;
    // The emitter takes a new cell when empty or while its last column leaves.
    assign emit_free    = !emit_valid_reg || (dst.ready && emit_on_last);
    assign hold_move    = hold_valid_reg && emit_free;
    assign src.ready    = !hold_valid_reg || emit_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (store_ctl.rd_en)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (hold_move)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_ctl.rd_en)
        begin
            hold_byte_reg <= src.data.source_byte;
            hold_prow_reg <= page_row;
            hold_bcol_reg <= byte_cnt_reg;
            hold_lcol_reg <= last_col;
            hold_page_reg <= page_now;
        end
    end

    // Cell assembly: stored rows below the closing row, the closing byte in its own
    // row, and zero for the rows a short final page lacks. Lanes of the store above
    // the closing row belong to an earlier page and are dropped.
    logic [7:0][7:0] rd_lanes;
    logic [7:0][7:0] cell_lanes;
    col_set_t        cell_cols;

    assign rd_lanes = {8'h00, store_rd_data};

    always_comb
    begin
        for (int r = 0; r < 8; r++)
        begin
            if (3'(r) < hold_prow_reg)
            begin
                cell_lanes[r] = rd_lanes[r];
            end
            else if (3'(r) == hold_prow_reg)
            begin
                cell_lanes[r] = hold_byte_reg;
            end
            else
            begin
                cell_lanes[r] = 8'h00;
            end
        end
    end

    assign cell_cols = h2v_transpose(cell_lanes, bit_order_reg);

    // ---------------------------------------------------------------------------
    // Emitter: holds one transposed cell and steps through its columns, one
    // transaction on dst per column.
    // ---------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_valid_reg <= 1'b0;
            emit_col_reg   <= '0;
        end
        else if (hold_move)
        begin
            emit_valid_reg <= 1'b1;
            emit_col_reg   <= '0;
        end
        else if (dst_fire)
        begin
            if (emit_on_last)
            begin
                emit_valid_reg <= 1'b0;
                emit_col_reg   <= '0;
            end
            else
            begin
                emit_col_reg <= emit_col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_move)
        begin
            emit_cols_reg <= cell_cols;
            emit_lcol_reg <= hold_lcol_reg;
            emit_bcol_reg <= hold_bcol_reg;
            emit_page_reg <= hold_page_reg;
        end
    end

    logic [BC_W+7:0] col_full;

    assign col_full = (BC_W + 8)'({emit_bcol_reg, emit_col_reg});

    assign dst.valid             = emit_valid_reg;
    assign dst.data.column_byte  = emit_cols_reg[emit_col_reg];
    assign dst.data.column_index = col_full[7:0];
    assign dst.data.page_index   = emit_page_reg;
    assign dst.data.last_of_cell = emit_on_last;

    // ---------------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------------
    `H2V_ASSERT_NEXT(a_hold_loads, clk, rst_n, store_ctl.rd_en, hold_valid_reg)
    `H2V_ASSERT_IMPL(a_col_in_cell, clk, rst_n, emit_valid_reg, emit_col_reg <= emit_lcol_reg)
    `H2V_ASSERT_NEXT(a_cell_restarts, clk, rst_n, dst_fire && emit_on_last, emit_col_reg == 3'd0)

endmodule

`default_nettype wire
